/* sv/isort_pkg.sv */
// ----------------------------------------------------------------------------
// isort_pkg
// Record and control types shared by the insertion sorter cells and top level.
// ----------------------------------------------------------------------------
package isort_pkg;

	localparam int KeyW  = 32;
	localparam int InfoW = 8;

	// one slot of the sorted chain
	typedef struct packed {
		logic                    valid;
		logic signed [KeyW-1:0]  key;
		logic        [InfoW-1:0] info;
	} rec_t;

	// broadcast control from the top level to every cell
	typedef struct packed {
		logic ins;    // insert the broadcast record
		logic drain;  // shift every slot one place toward cell 0
	} isort_ctrl_t;

endpackage

/* sv/insertion_sorter.sv */
// ----------------------------------------------------------------------------
// insertion_sorter
// Stable ascending insertion sort of key/info records in a chain of cells.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  item     item_valid/item_stall  key, info, last
//  res      res_valid/res_stall    key_res, info_res, last_res, overflow
//
//  one record is taken per cycle while item_stall is low: every cell compares
//  against the broadcast key and shifts or loads in the same cycle.
//  after the word marked last, the run drains one record per cycle from cell 0
//  while res_stall is low; item_stall is high for the whole drain.
//  res_stall freezes the chain, so the shown word holds.
//  records beyond CAPACITY are dropped and flag overflow on the whole run.
//  reset empties the chain at once.
// ----------------------------------------------------------------------------
module insertion_sorter
	import isort_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic signed [KeyW-1:0]  key,
	input  logic        [InfoW-1:0] info,
	input  logic                    last,
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic signed [KeyW-1:0]  key_res,
	output logic        [InfoW-1:0] info_res,
	output logic                    last_res,
	output logic                    overflow
);

	logic        draining_q;
	logic        dropped_q;
	logic        item_acc;
	logic        res_acc;
	logic        full;
	isort_ctrl_t ctrl;
	rec_t        new_rec;
	rec_t        empty_rec;
	rec_t        recs [CAPACITY];
	logic        gts  [CAPACITY];

	assign item_stall = draining_q;
	assign item_acc   = item_valid && !item_stall;
	assign res_valid  = draining_q;
	assign res_acc    = res_valid && !res_stall;
	assign full       = recs[CAPACITY-1].valid;

	assign ctrl.ins   = item_acc && !full;
	assign ctrl.drain = res_acc;
	assign new_rec    = '{valid: 1'b1, key: key, info: info};
	assign empty_rec  = '{valid: 1'b0, key: '0, info: '0};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		isort_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.new_rec   (new_rec),
			.left_rec  ((i == 0) ? empty_rec : recs[(i == 0) ? 0 : i-1]),
			.left_gt   ((i == 0) ? 1'b0 : gts[(i == 0) ? 0 : i-1]),
			.right_rec ((i == CAPACITY-1) ? empty_rec
			                              : recs[(i == CAPACITY-1) ? i : i+1]),
			.rec       (recs[i]),
			.gt        (gts[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q <= 1'b0;
			dropped_q  <= 1'b0;
		end else if (res_acc && last_res) begin
			draining_q <= 1'b0;
			dropped_q  <= 1'b0;
		end else if (item_acc) begin
			if (full) begin
				dropped_q <= 1'b1;
			end
			if (last) begin
				draining_q <= 1'b1;
			end
		end
	end

	assign key_res  = recs[0].key;
	assign info_res = recs[0].info;
	assign last_res = !recs[1].valid;
	assign overflow = dropped_q;

endmodule

/* sv/isort_cell.sv */
// ----------------------------------------------------------------------------
// isort_cell
// One slot of the systolic insertion chain: keeps, shifts in from a neighbor
// or loads the broadcast record.
// ----------------------------------------------------------------------------
module isort_cell
	import isort_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  isort_ctrl_t ctrl,
	input  rec_t        new_rec,
	input  rec_t        left_rec,
	input  logic        left_gt,
	input  rec_t        right_rec,
	output rec_t        rec,
	output logic        gt
);

	logic              valid_q;
	logic [KeyW-1:0]   key_q;
	logic [InfoW-1:0]  info_q;

	// an empty slot counts as greater, so the new word lands on the first one
	assign gt  = !valid_q || ($signed(key_q) > $signed(new_rec.key));
	assign rec = '{valid: valid_q, key: key_q, info: info_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.drain) begin
			valid_q <= right_rec.valid;
		end else if (ctrl.ins && gt) begin
			valid_q <= left_gt ? left_rec.valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.drain) begin
			key_q  <= right_rec.key;
			info_q <= right_rec.info;
		end else if (ctrl.ins && gt) begin
			if (left_gt) begin
				key_q  <= left_rec.key;
				info_q <= left_rec.info;
			end else begin
				key_q  <= new_rec.key;
				info_q <= new_rec.info;
			end
		end
	end

endmodule

/* sv/isort_checker.sv */
// ----------------------------------------------------------------------------
// isort_checker
// Port-level checks of the insertion sorter, bound to the top level.
// ----------------------------------------------------------------------------
module isort_checker
	import isort_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    item_valid,
	input logic                    item_stall,
	input logic                    last,
	input logic                    res_valid,
	input logic                    res_stall,
	input logic signed [KeyW-1:0]  key_res,
	input logic                    last_res
);

	// input is held off exactly while a run is being emitted
	a_stall_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid == item_stall)
		else $error("item_stall does not match drain");

	a_last_starts_out: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && last |=> res_valid)
		else $error("no output after last word");

	a_last_ends_out: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && last_res |=> !res_valid)
		else $error("output continues after last_res");

	// keys leave in ascending order
	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !last_res |=>
			res_valid && ($signed(key_res) >= $signed($past(key_res))))
		else $error("keys out of order");

endmodule

bind insertion_sorter isort_checker u_isort_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item_valid),
	.item_stall (item_stall),
	.last       (last),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.key_res    (key_res),
	.last_res   (last_res)
);
